[rtl/fkh_pkg.sv]
// ----------------------------------------------------------------------------
// fkh_pkg
// Shared constants, types and the FNV prime multiply for the key hash core.
// ----------------------------------------------------------------------------
package fkh_pkg;

    // fnv-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
    // prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_PRIME_LO    = 64'h0000_0000_0000_01B3;
    localparam int          FNV_PRIME_SHIFT = 40;

    // murmur3 fmix64 constants
    localparam logic [63:0] FMIX_C1    = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FMIX_C2    = 64'hC4CE_B9FE_1A85_EC53;
    localparam int          FMIX_SHIFT = 33;
    localparam int          TYPE_SHIFT = 16;

    // finalizer round count (two multiply rounds)
    localparam int          ROUND_W    = 2;
    localparam logic [ROUND_W-1:0] ROUND_FIRST = 2'd0;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one finished name waiting for finalization
    typedef struct packed {
        logic [63:0] hash;
        logic [15:0] query_type;
        logic [15:0] query_class;
    } t_key_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // finalizer sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH
    } t_fin_state;

    // multiply by the fnv 64-bit prime, modulo 2^64
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        logic [63:0] lo;
        lo = x * FNV_PRIME_LO;
        return (x << FNV_PRIME_SHIFT) + lo;
    endfunction

endpackage

[rtl/fnv_fmix_key_hash_core.sv]
// ----------------------------------------------------------------------------
// fnv_fmix_key_hash_core
// Owner-name key hash: FNV-1a 64 over the name bytes with type and class
// mixed in, finished by the fmix64 finalizer.
// ----------------------------------------------------------------------------
// path: a last byte's hash goes through the queue and the finalizer states
//   into the result register; throughput: one byte per cycle while the queue
//   has room; the finalizer works on one key at a time on one shared 32x32
//   multiplier, and a two-entry queue lets it overlap new names
// reset: synchronous, active low; the running hash returns to the offset
//   basis, queue and result register empty, no pass over storage needed
module fnv_fmix_key_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_owner_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_query_type,
    input  logic [15:0] i_query_class,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_key_hash
);

    fkh_pkg::t_queue_stat q_stat;
    fkh_pkg::t_key_entry  q_in;
    fkh_pkg::t_key_entry  q_head;
    logic                 q_push;
    logic                 q_pop;

    // byte folder
    fkh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_owner_byte  (i_owner_byte),
        .i_last_byte   (i_last_byte),
        .i_query_type  (i_query_type),
        .i_query_class (i_query_class),
        .i_stat        (q_stat),
        .o_q_push      (q_push),
        .o_q_entry     (q_in)
    );

    // queue of finished name hashes
    fkh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // finalizer and result register
    fkh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_stat     (q_stat),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_key_hash (o_key_hash)
    );

    assign full = q_stat.full;

endmodule

[rtl/fkh_front.sv]
// ----------------------------------------------------------------------------
// fkh_front
// Folds one owner byte per beat into the running FNV-1a hash and hands the
// hash of a finished name to the queue.
// ----------------------------------------------------------------------------
module fkh_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_owner_byte,
    input  logic                  i_last_byte,
    input  logic [15:0]           i_query_type,
    input  logic [15:0]           i_query_class,
    input  fkh_pkg::t_queue_stat  i_stat,
    output logic                  o_q_push,
    output fkh_pkg::t_key_entry   o_q_entry
);

    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic [63:0] folded;
    logic        accept;

    // byte fold
    assign accept = i_push && !i_stat.full;
    assign folded = fkh_pkg::fnv_mul(r_hash ^ {56'h0, i_owner_byte});

    always_comb begin
        n_hash = r_hash;
        if (accept) begin
            n_hash = i_last_byte ? fkh_pkg::FNV_BASIS : folded;
        end
    end

    // running hash register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= fkh_pkg::FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

    // hand off on the last byte
    assign o_q_push              = accept && i_last_byte;
    assign o_q_entry.hash        = folded;
    assign o_q_entry.query_type  = i_query_type;
    assign o_q_entry.query_class = i_query_class;

endmodule

[rtl/fkh_queue.sv]
// ----------------------------------------------------------------------------
// fkh_queue
// Short queue of finished name hashes between the byte folder and the
// finalizer.
// ----------------------------------------------------------------------------
module fkh_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fkh_pkg::t_key_entry   i_entry,
    input  logic                  i_pop,
    output fkh_pkg::t_key_entry   o_head,
    output fkh_pkg::t_queue_stat  o_stat
);

    fkh_pkg::t_key_entry r_mem [fkh_pkg::QUEUE_DEPTH];

    logic [fkh_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [fkh_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [fkh_pkg::QCNT_W-1:0] r_count;
    logic [fkh_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [fkh_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [fkh_pkg::QCNT_W-1:0] n_count;
    logic                       do_push;
    logic                       do_pop;

    // status
    assign o_stat.full  = (r_count == fkh_pkg::QCNT_W'(fkh_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == fkh_pkg::QPTR_W'(fkh_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == fkh_pkg::QPTR_W'(fkh_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[rtl/fkh_back.sv]
// ----------------------------------------------------------------------------
// fkh_back
// Mixes type and class into a queued name hash, runs the fmix64 finalizer on
// one shared 32x32 multiplier and holds the key in an output register.
// ----------------------------------------------------------------------------
module fkh_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fkh_pkg::t_key_entry   i_head,
    input  fkh_pkg::t_queue_stat  i_stat,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [63:0]           o_key_hash
);

    fkh_pkg::t_fin_state           r_state;
    fkh_pkg::t_fin_state           n_state;
    logic [fkh_pkg::ROUND_W-1:0]   r_round;
    logic [fkh_pkg::ROUND_W-1:0]   n_round;
    logic [63:0]                   r_x;
    logic [63:0]                   n_x;
    logic [63:0]                   r_acc;
    logic [63:0]                   n_acc;
    logic                          r_out_valid;
    logic [63:0]                   r_key;

    logic [63:0] mixed;
    logic [63:0] shifted;
    logic [63:0] mul_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic        out_pop;
    logic        ld_out;

    // type and class mix-in of a queued name hash
    assign mixed = fkh_pkg::fnv_mul(i_head.hash ^
                       (64'(i_head.query_type) << fkh_pkg::TYPE_SHIFT))
                   ^ 64'(i_head.query_class);

    // xor-shift step
    assign shifted = r_x ^ (r_x >> fkh_pkg::FMIX_SHIFT);

    // shared multiplier: low 64 bits built from three 32x32 partial products
    assign mul_c = (r_round == fkh_pkg::ROUND_FIRST) ? fkh_pkg::FMIX_C1 : fkh_pkg::FMIX_C2;
    assign mul_a = (r_state == fkh_pkg::ST_MUL_HL) ? r_x[63:32] : r_x[31:0];
    assign mul_b = (r_state == fkh_pkg::ST_MUL_LH) ? mul_c[63:32] : mul_c[31:0];
    assign prod  = mul_a * mul_b;

    assign out_pop = i_pop && r_out_valid;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_x     = r_x;
        n_acc   = r_acc;
        o_q_pop = 1'b0;
        ld_out  = 1'b0;
        unique case (r_state)
            fkh_pkg::ST_IDLE: begin
                if (!i_stat.empty) begin
                    o_q_pop = 1'b1;
                    n_x     = mixed;
                    n_round = fkh_pkg::ROUND_FIRST;
                    n_state = fkh_pkg::ST_SHIFT;
                end
            end
            fkh_pkg::ST_SHIFT: begin
                if (r_round == fkh_pkg::ROUND_LAST) begin
                    if (!r_out_valid || out_pop) begin
                        ld_out  = 1'b1;
                        n_state = fkh_pkg::ST_IDLE;
                    end
                end else begin
                    n_x     = shifted;
                    n_state = fkh_pkg::ST_MUL_LL;
                end
            end
            fkh_pkg::ST_MUL_LL: begin
                n_acc   = prod;
                n_state = fkh_pkg::ST_MUL_HL;
            end
            fkh_pkg::ST_MUL_HL: begin
                n_acc   = r_acc + {prod[31:0], 32'h0};
                n_state = fkh_pkg::ST_MUL_LH;
            end
            fkh_pkg::ST_MUL_LH: begin
                n_x     = r_acc + {prod[31:0], 32'h0};
                n_round = r_round + 1'b1;
                n_state = fkh_pkg::ST_SHIFT;
            end
            default: begin
                n_state = fkh_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fkh_pkg::ST_IDLE;
            r_round <= fkh_pkg::ROUND_FIRST;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_key <= shifted;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_key_hash = r_key;

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= fkh_pkg::ROUND_LAST)
        else $error("finalizer round out of range");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |-> (!r_out_valid || i_pop))
        else $error("key loaded over an untaken beat");

    a_take_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fkh_pkg::ST_IDLE && !i_stat.empty) |=> r_state == fkh_pkg::ST_SHIFT)
        else $error("queued hash not taken");

    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fkh_pkg::ST_MUL_LH |=>
            (r_state == fkh_pkg::ST_SHIFT && r_round == $past(r_round) + 1'b1))
        else $error("multiply round did not advance");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == fkh_pkg::ST_IDLE && !i_stat.empty))
        else $error("queue popped outside idle");
`endif

endmodule

[verif/fnv_fmix_key_hash_checker.sv]
// ----------------------------------------------------------------------------
// fnv_fmix_key_hash_checker
// Watches the byte and key channels of the key hash core, computes each key
// from the accepted byte beats and compares every popped key in order.
// ----------------------------------------------------------------------------
module fnv_fmix_key_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_owner_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_query_type,
    input  logic [15:0] i_query_class,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [63:0] i_key_hash,
    output int          o_mismatches,
    output int          o_keys_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] NAME_PRIME   = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] AVALANCHE_A  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] AVALANCHE_B  = 64'hc4ce_b9fe_1a85_ec53;
    localparam int          AVALANCHE_SH = 33;
    localparam int          TYPE_SH      = 16;
    localparam int          REPORT_LIMIT = 10;

    // hash of the name bytes seen so far in the current key
    logic [63:0] name_hash = OFFSET_BASIS;
    // keys computed but not yet popped, oldest first
    logic [63:0] expected_keys[$];

    initial begin
        o_mismatches   = 0;
        o_keys_pending = 0;
    end

    // fold one name byte into the running hash, modulo 2^64
    function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * NAME_PRIME;
    endfunction

    // mix in type and class, then the 64-bit avalanche finalizer
    function automatic logic [63:0] finish_key(input logic [63:0] h,
                                               input logic [15:0] qtype,
                                               input logic [15:0] qclass);
        logic [63:0] x;
        x = (h ^ ({48'd0, qtype} << TYPE_SH)) * NAME_PRIME;
        x = x ^ {48'd0, qclass};
        x = x ^ (x >> AVALANCHE_SH);
        x = x * AVALANCHE_A;
        x = x ^ (x >> AVALANCHE_SH);
        x = x * AVALANCHE_B;
        x = x ^ (x >> AVALANCHE_SH);
        return x;
    endfunction

    // key beats are checked before byte beats of the same edge
    always @(posedge i_clk) begin
        logic [63:0] h;
        logic [63:0] want;
        if (!i_rst_n) begin
            name_hash <= OFFSET_BASIS;
            expected_keys.delete();
        end else begin
            // popped key against the oldest computed one
            if (i_pop && !i_empty) begin
                if (expected_keys.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT)
                        $display("%0t: key beat with none outstanding: key_hash %h",
                                 $realtime, i_key_hash);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = expected_keys.pop_front();
                    if (i_key_hash !== want) begin
                        if (o_mismatches < REPORT_LIMIT)
                            $display("%0t: key_hash mismatch: expected %h actual %h",
                                     $realtime, want, i_key_hash);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            // accepted byte beat updates the name hash
            if (i_push && !i_full) begin
                h = fold_byte(name_hash, i_owner_byte);
                if (i_last_byte) begin
                    expected_keys.push_back(finish_key(h, i_query_type, i_query_class));
                    name_hash <= OFFSET_BASIS;
                end else begin
                    name_hash <= h;
                end
            end
        end
        o_keys_pending = expected_keys.size();
    end

endmodule

[verif/fnv_fmix_key_hash_core_tb.sv]
// ----------------------------------------------------------------------------
// fnv_fmix_key_hash_core_tb
// Drives owner-name byte streams into the key hash core with directed keys
// and then random keys under several idle and stall mixes; the checker
// computes and compares each key, and this module gives the verdict.
// ----------------------------------------------------------------------------
module fnv_fmix_key_hash_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int BYTES_PER_PHASE = 250;
    localparam int NUM_PHASES      = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_owner_byte;
    logic        i_last_byte;
    logic [15:0] i_query_type;
    logic [15:0] i_query_class;
    logic        empty;
    logic        pop;
    logic [63:0] o_key_hash;

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int keys_pending;
    int quiet_cycles = 0;

    fnv_fmix_key_hash_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_owner_byte  (i_owner_byte),
        .i_last_byte   (i_last_byte),
        .i_query_type  (i_query_type),
        .i_query_class (i_query_class),
        .empty         (empty),
        .pop           (pop),
        .o_key_hash    (o_key_hash)
    );

    fnv_fmix_key_hash_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_owner_byte   (i_owner_byte),
        .i_last_byte    (i_last_byte),
        .i_query_type   (i_query_type),
        .i_query_class  (i_query_class),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_key_hash     (o_key_hash),
        .o_mismatches   (mismatches),
        .o_keys_pending (keys_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // key side: random stalls at the current rate
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one byte beat, with a random idle gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic [15:0] qtype, input logic [15:0] qclass);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_owner_byte  <= b;
        i_last_byte   <= lst;
        i_query_type  <= qtype;
        i_query_class <= qclass;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off the byte side until every key has been popped
    task automatic wait_keys_drained();
        push <= 1'b0;
        while (keys_pending != 0) @(negedge i_clk);
    endtask

    // random names: mostly short, a few long
    task automatic send_random_names(input int n_bytes);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
            for (k = 0; k < len; k++)
                send_byte(8'($urandom_range(255)), (k == len - 1),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)));
            sent += len;
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [7:0] dns_name [17];
        int i;
        int phase;

        dns_name = '{8'h03, "w", "w", "w", 8'h07, "e", "x", "a", "m",
                     "p", "l", "e", 8'h03, "c", "o", "m", 8'h00};
        i_rst_n            = 1'b0;
        push               = 1'b0;
        i_owner_byte       = 8'h00;
        i_last_byte        = 1'b0;
        i_query_type       = 16'h0000;
        i_query_class      = 16'h0000;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte keys at the field extremes, back to back
        send_byte(8'h00, 1'b1, 16'h0000, 16'h0000);
        send_byte(8'hff, 1'b1, 16'hffff, 16'hffff);
        send_byte(8'hff, 1'b1, 16'h0000, 16'hffff);
        send_byte(8'h00, 1'b1, 16'hffff, 16'h0000);
        // encoded name; type and class on inner bytes must be ignored
        for (i = 0; i < 17; i++)
            send_byte(dns_name[i], (i == 16),
                      (i == 16) ? 16'h001c : 16'($urandom_range(65535)),
                      (i == 16) ? 16'h0001 : 16'($urandom_range(65535)));
        wait_keys_drained();

        // random names under each idle and stall mix
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 88;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 88;
                end
                default: begin
                    sender_idle_pct    = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            send_random_names(BYTES_PER_PHASE);
            wait_keys_drained();
        end

        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && keys_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
